// File: rtl/core/dss_pkg.sv
// dss_pkg: opcodes, status codes, controller states and the command/status
// structs shared by the two-stack controller and datapath
// no dependencies
package dss_pkg;

  localparam int WORD_W = 32;
  localparam int OPC_W  = 3;
  localparam int STS_W  = 2;

  // operation codes carried by an input word
  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_LO = 3'd0,
    OP_PUSH_HI = 3'd1,
    OP_POP_LO  = 3'd2,
    OP_POP_HI  = 3'd3,
    OP_SHOW_LO = 3'd4,
    OP_SHOW_HI = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic push_wr;     // write the push word and bump the count
    logic pop_start;   // drop the count and read the top entry
    logic show_start;  // start a top-to-bottom read of one stack
    logic hi_sel;      // operation targets the high stack
    logic ld_fail;     // load a failure result
    st_t  fail_code;   // status of that failure result
    logic ld_mem;      // load a result from the read data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic lo_empty;
    logic hi_empty;
    logic rem_last;    // the word in the read register is the last of its run
  } sts_t;

endpackage

// File: rtl/core/dss_ctrl.sv
// dss_ctrl: state machine that decodes operations and paces the result stream
// depends on dss_pkg
module dss_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dss_pkg::OPC_W-1:0]  in_opcode,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dss_pkg::cmd_t              cmd,
  input  dss_pkg::sts_t              sts
);
  import dss_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   acc;

  // output register is free or being emptied this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign acc       = (state_r == S_IDLE) && in_valid && slot_free;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (op_t'(in_opcode))
            OP_POP_LO, OP_SHOW_LO: if (!sts.lo_empty) state_nxt = S_DRAIN;
            OP_POP_HI, OP_SHOW_HI: if (!sts.hi_empty) state_nxt = S_DRAIN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DRAIN: begin
        if (slot_free && sts.rem_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd           = '0;
    cmd.fail_code = ST_OK;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = slot_free;
        if (acc) begin
          case (op_t'(in_opcode))
            OP_PUSH_LO, OP_PUSH_HI: begin
              cmd.hi_sel    = (op_t'(in_opcode) == OP_PUSH_HI);
              out_valid_nxt = 1'b1;
              if (sts.full) begin
                cmd.ld_fail   = 1'b1;
                cmd.fail_code = ST_FULL;
              end else begin
                cmd.push_wr = 1'b1;
              end
            end
            OP_POP_LO, OP_POP_HI: begin
              cmd.hi_sel = (op_t'(in_opcode) == OP_POP_HI);
              if (cmd.hi_sel ? sts.hi_empty : sts.lo_empty) begin
                cmd.ld_fail   = 1'b1;
                cmd.fail_code = ST_EMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                cmd.pop_start = 1'b1;
              end
            end
            OP_SHOW_LO, OP_SHOW_HI: begin
              cmd.hi_sel = (op_t'(in_opcode) == OP_SHOW_HI);
              if (cmd.hi_sel ? sts.hi_empty : sts.lo_empty) begin
                cmd.ld_fail   = 1'b1;
                cmd.fail_code = ST_EMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                cmd.show_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          cmd.ld_mem    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result from memory is only taken while draining
  a_ld_mem_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_mem |-> state_r == S_DRAIN)
    else $error("memory result loaded outside drain");

  // the last word of a run returns the controller to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_mem && sts.rem_last) |=> state_r == S_IDLE)
    else $error("drain did not end on last word");

  // a read started by pop or show puts the controller into drain
  a_start_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_start || cmd.show_start) |=> state_r == S_DRAIN)
    else $error("read started without drain");

endmodule

// File: rtl/core/dss_dp.sv
// dss_dp: shared word memory, the two stack counts, read pointer and result
// registers; depends on dss_pkg
module dss_dp #(
  parameter int DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [dss_pkg::WORD_W-1:0]  in_push_value,
  input  dss_pkg::cmd_t                      cmd,
  output dss_pkg::sts_t                      sts,
  output logic [dss_pkg::STS_W-1:0]          out_status,
  output logic signed [dss_pkg::WORD_W-1:0]  out_item_value,
  output logic                               out_last_of_run
);
  import dss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  logic [CW-1:0] cnt_lo_r, cnt_lo_nxt;
  logic [CW-1:0] cnt_hi_r, cnt_hi_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          dir_up_r, dir_up_nxt;

  logic [CW:0]   cnt_sum;
  logic [CW-1:0] cnt_sel;
  logic [CW-1:0] wr_addr_w, top_addr_w;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] ptr_step;

  logic [STS_W-1:0]  status_r;
  logic [WORD_W-1:0] value_r;
  logic              last_r;

  // occupancy status
  assign cnt_sum      = {1'b0, cnt_lo_r} + {1'b0, cnt_hi_r};
  assign sts.full     = cnt_sum >= {1'b0, DEPTH_C};
  assign sts.lo_empty = (cnt_lo_r == '0);
  assign sts.hi_empty = (cnt_hi_r == '0);
  assign sts.rem_last = (rem_r == CW'(1));

  // addresses: push slot, and top-of-stack slot for pop or show
  assign cnt_sel    = cmd.hi_sel ? cnt_hi_r : cnt_lo_r;
  assign wr_addr_w  = cmd.hi_sel ? (DEPTH_C - CW'(1) - cnt_hi_r) : cnt_lo_r;
  assign top_addr_w = cmd.hi_sel ? (DEPTH_C - cnt_hi_r) : (cnt_lo_r - CW'(1));
  assign ptr_step   = dir_up_r ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));

  // counts, read pointer and run length
  always_comb begin
    cnt_lo_nxt = cnt_lo_r;
    cnt_hi_nxt = cnt_hi_r;
    rem_nxt    = rem_r;
    ptr_nxt    = ptr_r;
    dir_up_nxt = dir_up_r;
    rd_en      = 1'b0;
    rd_addr    = ptr_r;
    if (cmd.push_wr) begin
      if (cmd.hi_sel) cnt_hi_nxt = cnt_hi_r + CW'(1);
      else            cnt_lo_nxt = cnt_lo_r + CW'(1);
    end
    if (cmd.pop_start || cmd.show_start) begin
      rd_en      = 1'b1;
      rd_addr    = top_addr_w[AW-1:0];
      ptr_nxt    = top_addr_w[AW-1:0];
      dir_up_nxt = cmd.hi_sel;
      rem_nxt    = cmd.pop_start ? CW'(1) : cnt_sel;
      if (cmd.pop_start) begin
        if (cmd.hi_sel) cnt_hi_nxt = cnt_hi_r - CW'(1);
        else            cnt_lo_nxt = cnt_lo_r - CW'(1);
      end
    end
    if (cmd.ld_mem) begin
      rem_nxt = rem_r - CW'(1);
      ptr_nxt = ptr_step;
      if (!sts.rem_last) begin
        rd_en   = 1'b1;
        rd_addr = ptr_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
      rem_r    <= '0;
    end else begin
      cnt_lo_r <= cnt_lo_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      rem_r    <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    dir_up_r <= dir_up_nxt;
  end

  // shared memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_wr) mem[wr_addr_w[AW-1:0]] <= in_push_value;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      status_r <= ST_OK;
      value_r  <= in_push_value;
      last_r   <= 1'b1;
    end else if (cmd.ld_fail) begin
      status_r <= cmd.fail_code;
      value_r  <= '0;
      last_r   <= 1'b1;
    end else if (cmd.ld_mem) begin
      status_r <= ST_OK;
      value_r  <= rd_data_r;
      last_r   <= sts.rem_last;
    end
  end

  assign out_status      = status_r;
  assign out_item_value  = value_r;
  assign out_last_of_run = last_r;

  // the two stacks never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sum <= {1'b0, DEPTH_C})
    else $error("stack counts exceed memory depth");

  // a push never lands on a full memory
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !sts.full)
    else $error("push written while full");

  // a pop shrinks the total of the two counts by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_start |=> (cnt_lo_r + cnt_hi_r) == ($past(cnt_lo_r) + $past(cnt_hi_r) - CW'(1)))
    else $error("pop did not drop the count by one");

endmodule

// File: rtl/core/dual_stack_shared_memory.sv
// dual_stack_shared_memory: two stacks in one memory, low one growing up
// and high one growing down; depends on dss_pkg, dss_ctrl, dss_dp
//
//   port group  dir  handshake            payload
//   in_*        in   in_valid/in_ready    in_opcode, in_push_value
//   out_*       out  out_valid/out_ready  out_status, out_item_value, out_last_of_run
//
// push and failed operations: result loaded from the accepted word; next word taken once the result register is free
// pop: the top entry passes through the registered memory read before it is loaded as the result
// show of n words: one word per cycle from the single read port while out_ready is high;
// no input is taken until the last word of the run is loaded
// rst_n clears both stack counts; memory contents are not cleared
// out_ready low holds the result register and stalls the read stream and input
module dual_stack_shared_memory #(
  parameter int DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dss_pkg::OPC_W-1:0]          in_opcode,
  input  logic signed [dss_pkg::WORD_W-1:0]  in_push_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dss_pkg::STS_W-1:0]          out_status,
  output logic signed [dss_pkg::WORD_W-1:0]  out_item_value,
  output logic                               out_last_of_run
);
  import dss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // memory, counts and result word
  dss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push_value   (in_push_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_item_value  (out_item_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: dv/dual_stack_shared_memory_tb.sv
// dual_stack_shared_memory_tb: drives push, pop and show words into the two-stack
// block, predicts each result word and checks them in order against the outputs
// depends on dss_pkg and dual_stack_shared_memory
`timescale 1ns / 100ps

module dual_stack_shared_memory_tb;
  import dss_pkg::*;

  localparam int TB_DEPTH      = 32;
  localparam int RANDOM_WORDS  = 220;
  localparam int QUIET_TAIL    = 40;
  localparam int PHASE_LEN     = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;

  // opcodes the block has no operation for
  localparam logic [OPC_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_UNUSED_7 = 3'd7;

  // random stimulus phases
  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIXED = 2;

  typedef struct packed {
    st_t              status;
    logic [WORD_W-1:0] value;
    logic             last;
  } result_word_t;

  // tracks both stacks and the result words still owed by the block
  class two_stack_tracker;
    logic [WORD_W-1:0] mem_words [TB_DEPTH];
    int                lo_count = 0;
    int                hi_count = 0;
    int                errors   = 0;
    result_word_t      expected_words [$];

    function void owe(st_t status, logic [WORD_W-1:0] value, logic last);
      result_word_t w;
      w.status = status;
      w.value  = value;
      w.last   = last;
      expected_words.push_back(w);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // accepted input word: update the stacks and queue its results
    function void note_word(logic [OPC_W-1:0] op, logic [WORD_W-1:0] val);
      int n;
      int addr;
      case (op)
        OP_PUSH_LO, OP_PUSH_HI: begin
          if (lo_count + hi_count >= TB_DEPTH) begin
            owe(ST_FULL, '0, 1'b1);
          end else begin
            if (op == OP_PUSH_LO) begin
              mem_words[lo_count] = val;
              lo_count++;
            end else begin
              hi_count++;
              mem_words[TB_DEPTH - hi_count] = val;
            end
            owe(ST_OK, val, 1'b1);
          end
        end
        OP_POP_LO, OP_POP_HI: begin
          n = (op == OP_POP_LO) ? lo_count : hi_count;
          if (n == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else if (op == OP_POP_LO) begin
            lo_count--;
            owe(ST_OK, mem_words[lo_count], 1'b1);
          end else begin
            addr = TB_DEPTH - hi_count;
            hi_count--;
            owe(ST_OK, mem_words[addr], 1'b1);
          end
        end
        OP_SHOW_LO, OP_SHOW_HI: begin
          n = (op == OP_SHOW_LO) ? lo_count : hi_count;
          if (n == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            // top of stack first, last flag on the bottom entry
            for (int i = 0; i < n; i++) begin
              addr = (op == OP_SHOW_LO) ? (n - 1 - i) : (TB_DEPTH - n + i);
              owe(ST_OK, mem_words[addr], (i + 1 == n));
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    // accepted result word: compare against the oldest expected word
    function void check_word(logic [STS_W-1:0] status, logic [WORD_W-1:0] value,
                             logic last);
      result_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: status %0d item_value %08h last %0b",
               status, value, last);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (status !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, status);
        errors++;
      end
      if (value !== w.value) begin
        $error("item_value: expected %08h, actual %08h", w.value, value);
        errors++;
      end
      if (last !== w.last) begin
        $error("last_of_run: expected %0b, actual %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic [OPC_W-1:0]         in_opcode       = '0;
  logic signed [WORD_W-1:0] in_push_value   = '0;
  logic                     out_valid;
  logic                     out_ready       = 1'b0;
  logic [STS_W-1:0]         out_status;
  logic signed [WORD_W-1:0] out_item_value;
  logic                     out_last_of_run;

  two_stack_tracker tracker;
  logic             quiet     = 1'b0;
  int               idle_run  = 0;

  dual_stack_shared_memory #(
    .DEPTH(TB_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_last_of_run(out_last_of_run)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // present one input word and hold it until accepted
  task automatic send_word(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] val);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_push_value <= val;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(op, val);
  endtask

  // random sender gap, skipped in the quiet tail and in some windows
  task automatic maybe_gap(input int n);
    int len;
    if (!quiet && ((n / 16) % 3 != 2) && $urandom_range(0, 99) < 25) begin
      len = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // hold off the sender until every owed result word is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OPC_W-1:0] pick_op(input int phase);
    int roll;
    logic hi;
    roll = $urandom_range(0, 99);
    hi   = 1'($urandom_range(0, 1));
    case (phase)
      PH_FILL: begin
        if (roll < 85)      return hi ? OP_PUSH_HI : OP_PUSH_LO;
        else if (roll < 92) return hi ? OP_POP_HI : OP_POP_LO;
        else                return hi ? OP_SHOW_HI : OP_SHOW_LO;
      end
      PH_DRAIN: begin
        if (roll < 20)      return hi ? OP_PUSH_HI : OP_PUSH_LO;
        else if (roll < 85) return hi ? OP_POP_HI : OP_POP_LO;
        else                return hi ? OP_SHOW_HI : OP_SHOW_LO;
      end
      default: begin
        if (roll < 40)      return hi ? OP_PUSH_HI : OP_PUSH_LO;
        else if (roll < 70) return hi ? OP_POP_HI : OP_POP_LO;
        else                return hi ? OP_SHOW_HI : OP_SHOW_LO;
      end
    endcase
  endfunction

  // receiver: random stall bursts, none in the quiet tail
  initial begin
    int len;
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 99) >= 20) begin
        out_ready <= 1'b1;
      end else begin
        len = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (len - 1) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_word(out_status, out_item_value, out_last_of_run);
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("dual_stack_shared_memory_tb failed");
    $finish;
  end

  // main sequence
  initial begin
    int sent;
    int phase;
    logic [OPC_W-1:0] op;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extreme words, every operation, unused opcodes
    send_word(OP_SHOW_LO, 32'h0000_0000);
    send_word(OP_SHOW_HI, 32'hFFFF_FFFF);
    send_word(OP_POP_LO, 32'hFFFF_FFFF);
    send_word(OP_POP_HI, 32'h0000_0000);
    send_word(OP_PUSH_LO, 32'h7FFF_FFFF);
    send_word(OP_PUSH_LO, 32'h8000_0000);
    maybe_gap(0);
    send_word(OP_PUSH_HI, 32'h0000_0000);
    send_word(OP_PUSH_HI, 32'hFFFF_FFFF);
    send_word(OP_PUSH_HI, 32'h5A5A_A5A5);
    send_word(OP_SHOW_LO, 32'h0000_0000);
    send_word(OP_SHOW_HI, 32'h0000_0000);
    send_word(OP_UNUSED_6, 32'h1234_5678);
    send_word(OP_UNUSED_7, 32'hFFFF_FFFF);
    send_word(OP_POP_HI, 32'h0000_0000);
    send_word(OP_POP_LO, 32'h0000_0000);
    send_word(OP_POP_HI, 32'h0000_0000);
    send_word(OP_POP_HI, 32'h0000_0000);
    send_word(OP_POP_HI, 32'h0000_0000);
    send_word(OP_POP_LO, 32'h0000_0000);
    send_word(OP_POP_LO, 32'h0000_0000);
    wait_drained();

    // fill both stacks until they meet, overflow each side, then show both
    sent = 0;
    while (tracker.lo_count + tracker.hi_count < TB_DEPTH) begin
      maybe_gap(sent);
      send_word($urandom_range(0, 1) ? OP_PUSH_HI : OP_PUSH_LO, pick_value());
      sent++;
    end
    send_word(OP_PUSH_LO, pick_value());
    send_word(OP_PUSH_HI, pick_value());
    send_word(OP_SHOW_LO, pick_value());
    send_word(OP_SHOW_HI, pick_value());
    sent += 4;

    // random phases of filling, draining and mixed traffic
    while (sent < RANDOM_WORDS) begin
      if (sent >= RANDOM_WORDS - QUIET_TAIL) quiet = 1'b1;
      maybe_gap(sent);
      if ($urandom_range(0, 99) < 3) begin
        // noise word, no result
        send_word($urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6, $urandom);
      end else begin
        phase = (sent / PHASE_LEN) % 3;
        op    = pick_op(phase);
        send_word(op, pick_value());
        sent++;
      end
      if (sent == RANDOM_WORDS / 2) wait_drained();
    end

    // let the last results come out
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("dual_stack_shared_memory_tb passed");
    end else begin
      $display("dual_stack_shared_memory_tb failed");
    end
    $finish;
  end

endmodule
